FILE: src/dsce_pkg.sv
// ----------------------------------------------------------------------------
// dsce_pkg: shared types and constants of the DNS server cookie engine
// Payload structs, register and status codes, controller types, SHA-256 tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dsce_pkg;

    typedef struct packed {
        logic        func;
        logic [1:0]  addr_kind;
        logic [63:0] client_addr_high;
        logic [63:0] client_addr_low;
        logic [63:0] client_cookie;
        logic [31:0] cookie_nonce;
        logic [31:0] cookie_time;
        logic [63:0] received_hash;
        logic [5:0]  received_length;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_nonce;
        logic [31:0] out_time;
        logic [63:0] cookie_hash;
        logic [4:0]  cookie_length;
    } t_out;

    localparam logic [2:0] CFG_ALGORITHM  = 3'd0;
    localparam logic [2:0] CFG_SECRET_LEN = 3'd1;
    localparam logic [2:0] CFG_SECRET_W0  = 3'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_BADMSG  = 2'd2;

    localparam logic [1:0] AK_NONE = 2'd0;
    localparam logic [1:0] AK_V4   = 2'd1;
    localparam logic [1:0] AK_V6   = 2'd2;

    localparam logic       FUNC_CHECK = 1'b1;

    localparam logic [1:0] BLK_IPAD  = 2'd0;
    localparam logic [1:0] BLK_INNER = 2'd1;
    localparam logic [1:0] BLK_OPAD  = 2'd2;
    localparam logic [1:0] BLK_OUTER = 2'd3;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

    typedef enum logic [2:0] {
        S_IDLE, S_EVAL, S_FNV, S_SHA_LOAD, S_SHA_RUN, S_SHA_FOLD, S_DONE
    } t_state;

    typedef struct packed {
        logic       latch;
        logic       fnv_init;
        logic       fnv_step;
        logic       sha_load;
        logic       sha_round;
        logic       sha_fold;
        logic [1:0] blk;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic hmac;
        logic fnv_last;
        logic round_last;
    } t_sts;

    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage
`default_nettype wire

FILE: src/dsce_ctrl.sv
// ----------------------------------------------------------------------------
// dsce_ctrl: sequencer of the cookie engine
// Steps the FNV byte loop or the four SHA-256 compressions and owns the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dsce_ctrl
    import dsce_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_blk, n_blk;
    logic       r_ov, n_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_blk   <= BLK_IPAD;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_blk   <= n_blk;
            r_ov    <= n_ov;
        end
    end

    always_comb begin
        n_state = r_state;
        n_blk   = r_blk;
        o_cmd   = '0;
        o_cmd.blk = r_blk;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.err) begin
                    n_state = S_DONE;
                end else if (i_sts.hmac) begin
                    n_blk   = BLK_IPAD;
                    n_state = S_SHA_LOAD;
                end else begin
                    o_cmd.fnv_init = 1'b1;
                    n_state = S_FNV;
                end
            end
            S_FNV: begin
                o_cmd.fnv_step = 1'b1;
                if (i_sts.fnv_last) n_state = S_DONE;
            end
            S_SHA_LOAD: begin
                o_cmd.sha_load = 1'b1;
                n_state = S_SHA_RUN;
            end
            S_SHA_RUN: begin
                o_cmd.sha_round = 1'b1;
                if (i_sts.round_last) n_state = S_SHA_FOLD;
            end
            S_SHA_FOLD: begin
                o_cmd.sha_fold = 1'b1;
                if (r_blk == BLK_OUTER) begin
                    n_state = S_DONE;
                end else begin
                    n_blk   = r_blk + 2'd1;
                    n_state = S_SHA_LOAD;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_ov || i_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ov = o_cmd.finish ? 1'b1 : (r_ov & ~i_ready);
    end

    assign o_valid = r_ov;

endmodule
`default_nettype wire

FILE: src/dsce_dp.sv
// ----------------------------------------------------------------------------
// dsce_dp: datapath of the cookie engine
// Input latch, FNV-1a byte unit, one-round-per-cycle SHA-256 and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dsce_dp
    import dsce_pkg::*;
#(
    parameter int SECRET_BYTES = 32
) (
    input  wire logic                      i_clk,
    input  wire t_in                       i_data,
    input  wire logic [1:0]                i_alg,
    input  wire logic [5:0]                i_klen,
    input  wire logic [SECRET_BYTES*8-1:0] i_secret,
    input  wire t_cmd                      i_cmd,
    output t_sts                           o_sts,
    output t_out                           o_data
);

    t_in          r_in;
    t_out         r_out;
    logic [255:0] r_front, r_key;
    logic [6:0]   r_cnt;
    logic [63:0]  r_fnv;
    logic [255:0] r_h, r_inner, r_wk;
    logic [31:0]  r_w [16];
    logic [5:0]   r_rnd;

    logic         nt, hmac;
    logic [1:0]   err;
    logic [4:0]   size;
    logic [255:0] key_seq, key_m;
    logic [63:0]  nt_le, ccb;
    logic [4:0]   alen;
    logic [5:0]   l1;
    logic [6:0]   ntot;
    t_out         n_out;
    logic [63:0]  hv, fnv_sw;

    assign nt   = i_alg[0];
    assign hmac = i_alg[1];
    assign size = nt ? 5'd16 : 5'd8;
    assign ccb  = r_in.client_cookie;
    assign nt_le = {r_in.cookie_nonce[7:0], r_in.cookie_nonce[15:8],
                    r_in.cookie_nonce[23:16], r_in.cookie_nonce[31:24],
                    r_in.cookie_time[7:0], r_in.cookie_time[15:8],
                    r_in.cookie_time[23:16], r_in.cookie_time[31:24]};

    for (genvar g = 0; g < 32; g++) begin : g_key
        if (g < SECRET_BYTES) begin : g_have
            assign key_seq[255-8*g -: 8] = i_secret[8*g +: 8];
        end else begin : g_none
            assign key_seq[255-8*g -: 8] = 8'h00;
        end
        assign key_m[255-8*g -: 8] = (6'(g) < i_klen) ? key_seq[255-8*g -: 8] : 8'h00;
    end

    // early verdicts, tested in the order of precedence
    always_comb begin
        err = ST_OK;
        if (r_in.func == FUNC_CHECK) begin
            if (r_in.received_length == 6'd0 || r_in.addr_kind == AK_NONE || i_klen == 6'd0)
                err = ST_INVALID;
            else if (r_in.received_length != {1'b0, size})
                err = ST_BADMSG;
        end else if (i_klen == 6'd0) begin
            err = ST_INVALID;
        end
    end

    always_comb begin
        case (r_in.addr_kind)
            AK_V4:   alen = 5'd4;
            AK_V6:   alen = 5'd16;
            default: alen = 5'd0;
        endcase
    end
    assign l1   = 6'(alen) + (nt ? 6'd16 : 6'd8);
    assign ntot = 7'(l1) + 7'(i_klen);

    // FNV byte stream: address, nonce and time, client cookie, then key
    logic [127:0] after_addr;
    logic [255:0] front;
    logic [7:0]   fbyte;
    logic [63:0]  hx, fnv_n;
    assign after_addr = nt ? {nt_le, ccb} : {ccb, 64'd0};
    always_comb begin
        case (r_in.addr_kind)
            AK_V6:   front = {r_in.client_addr_high, r_in.client_addr_low, after_addr};
            AK_V4:   front = {r_in.client_addr_low[31:0], after_addr, 96'd0};
            default: front = {after_addr, 128'd0};
        endcase
    end
    assign fbyte = (r_cnt < 7'(l1)) ? r_front[255:248] : r_key[255:248];
    assign hx    = r_fnv ^ {56'd0, fbyte};
    assign fnv_n = (hx << 40) + hx * 64'h1b3;

    // SHA-256 block selection
    logic [191:0] addr_blk;
    logic [255:0] seg;
    logic [63:0]  in_bits;
    logic [511:0] blk;
    always_comb begin
        case (r_in.addr_kind)
            AK_V6:   addr_blk = {r_in.client_addr_high, r_in.client_addr_low, 8'h80, 56'd0};
            AK_V4:   addr_blk = {r_in.client_addr_low[31:0], 8'h80, 152'd0};
            default: addr_blk = {8'h80, 184'd0};
        endcase
        seg     = nt ? {nt_le, addr_blk} : {addr_blk, 64'd0};
        in_bits = {54'd0, 10'(7'd72 + (nt ? 7'd8 : 7'd0) + 7'(alen)) << 3};
        case (i_cmd.blk)
            BLK_IPAD:  blk = {key_m ^ {32{8'h36}}, {32{8'h36}}};
            BLK_INNER: blk = {ccb, seg, 128'd0, in_bits};
            BLK_OPAD:  blk = {key_m ^ {32{8'h5c}}, {32{8'h5c}}};
            default:   blk = {r_inner, 8'h80, 184'd0, 64'd768};
        endcase
    end

    // one compression round
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wn;
    assign {a, b, c, d, e, f, g, h} = r_wk;
    assign t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
              + ((e & f) ^ (~e & g)) + SHA_K[r_rnd] + r_w[0];
    assign t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
              + ((a & b) ^ (a & c) ^ (b & c));
    assign wn = r_w[0]
              + ({r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3))
              + r_w[9]
              + ({r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
                 ^ (r_w[14] >> 10));

    logic [255:0] h_sum;
    always_comb begin
        for (int i = 0; i < 8; i++)
            h_sum[255-32*i -: 32] = r_h[255-32*i -: 32] + r_wk[255-32*i -: 32];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) r_in <= i_data;
        if (i_cmd.fnv_init) begin
            r_front <= front;
            r_key   <= key_seq;
            r_cnt   <= 7'd0;
            r_fnv   <= FNV_BASIS;
        end else if (i_cmd.fnv_step) begin
            r_fnv <= fnv_n;
            r_cnt <= r_cnt + 7'd1;
            if (r_cnt < 7'(l1)) r_front <= r_front << 8;
            else                r_key   <= r_key << 8;
        end
        if (i_cmd.sha_load) begin
            r_rnd <= 6'd0;
            for (int i = 0; i < 16; i++) r_w[i] <= blk[511-32*i -: 32];
            if (i_cmd.blk == BLK_IPAD || i_cmd.blk == BLK_OPAD) begin
                r_h  <= SHA_IV;
                r_wk <= SHA_IV;
            end else begin
                r_wk <= r_h;
            end
            // keep the inner digest for the outer message
            if (i_cmd.blk == BLK_OPAD) r_inner <= r_h;
        end else if (i_cmd.sha_round) begin
            r_rnd <= r_rnd + 6'd1;
            r_wk  <= {t1 + t2, a, b, c, d + t1, e, f, g};
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= wn;
        end else if (i_cmd.sha_fold) begin
            r_h <= h_sum;
        end
        if (i_cmd.finish) r_out <= n_out;
    end

    // the outer block takes the inner digest from r_inner; r_h chains the outer hash
    always_comb begin
        for (int i = 0; i < 8; i++) fnv_sw[63-8*i -: 8] = r_fnv[8*i +: 8];
        hv    = hmac ? r_h[255:192] : fnv_sw;
        n_out = '0;
        if (err != ST_OK) begin
            n_out.status = err;
        end else begin
            n_out.out_nonce     = nt ? r_in.cookie_nonce : 32'd0;
            n_out.out_time      = nt ? r_in.cookie_time : 32'd0;
            n_out.cookie_hash   = hv;
            n_out.cookie_length = size;
            n_out.status = (r_in.func == FUNC_CHECK && hv != r_in.received_hash)
                         ? ST_BADMSG : ST_OK;
        end
    end

    assign o_sts.err        = (err != ST_OK);
    assign o_sts.hmac       = hmac;
    assign o_sts.fnv_last   = (r_cnt == ntot - 7'd1);
    assign o_sts.round_last = (r_rnd == 6'd63);
    assign o_data = r_out;

endmodule
`default_nettype wire

FILE: src/dns_server_cookie_engine_core.sv
// ----------------------------------------------------------------------------
// dns_server_cookie_engine_core: DNS server cookie generator and checker
// FNV-1a-64 or HMAC-SHA256-64 server cookies from a configured secret.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+----------------------------
// request  | in        | i_valid / o_ready   | i_data  (t_in)
// result   | out       | o_valid / i_ready   | o_data  (t_out)
// config   | in        | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// An FNV cookie hashes n bytes (up to 64) on the one-byte-per-cycle FNV unit.
// An HMAC cookie runs four SHA-256 compressions of 64 rounds on the single
// round unit. One transaction is in work at a time; a finished result waits
// in the output register while the next request is taken. Reset is
// synchronous, active low, and clears the configuration registers and the
// sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dns_server_cookie_engine_core
    import dsce_pkg::*;
#(
    parameter int SECRET_BYTES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in         i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out             o_data,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);

    localparam logic [5:0] KEY_MAX = 6'(SECRET_BYTES);

    logic [1:0]                r_alg;
    logic [5:0]                r_slen;
    logic [SECRET_BYTES*8-1:0] r_secret;
    logic [5:0]                klen;
    t_cmd                      cmd;
    t_sts                      sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alg  <= 2'd0;
            r_slen <= 6'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ALGORITHM)  r_alg  <= i_cfg_data[1:0];
            if (i_cfg_idx == CFG_SECRET_LEN) r_slen <= i_cfg_data[5:0];
        end
    end

    // secret bytes: word k carries bytes 8k to 8k+7, lowest byte first
    for (genvar gb = 0; gb < SECRET_BYTES; gb++) begin : g_sec
        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_secret[8*gb +: 8] <= 8'h00;
            else if (i_cfg_we && i_cfg_idx == CFG_SECRET_W0 + 3'(gb / 8))
                r_secret[8*gb +: 8] <= i_cfg_data[8*(gb % 8) +: 8];
        end
    end

    // clamp the secret length to the stored bytes
    assign klen = (r_slen > KEY_MAX) ? KEY_MAX : r_slen;

    dsce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    dsce_dp #(.SECRET_BYTES(SECRET_BYTES)) u_dp (
        .i_clk    (i_clk),
        .i_data   (i_data),
        .i_alg    (r_alg),
        .i_klen   (klen),
        .i_secret (r_secret),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_data   (o_data)
    );

endmodule
`default_nettype wire
